// ----- design/pfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the entry training function of the prefetch predictor.
// No dependencies; used by the controller, the datapath and the top level.
package pfp_pkg;

  localparam int unsigned RID_W      = 32;
  localparam int unsigned PC_W       = 32;
  localparam int unsigned TID_W      = 5;
  localparam int unsigned PAGE_W     = 48;
  localparam int unsigned CTR_W      = 3;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned S_TDATA_W  = 120;
  localparam int unsigned M_TDATA_W  = 8;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_SUPERPAGE_SHIFT = 1'b0;

  localparam logic [RID_W-1:0]   RID_RESET     = 32'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 3'd2;
  localparam logic [CTR_W-1:0]   CTR_MAX       = 3'd7;
  localparam logic [CTR_W-1:0]   CTR_THRESHOLD = 3'd3;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [CTR_W-1:0]  ctr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    entry_t ent;
    logic   hit;
  } train_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic rem;
    logic commit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

  function automatic train_t train_entry(entry_t cur, logic [PAGE_W-1:0] page,
                                         logic [SHIFT_W-1:0] sh);
    train_t res;
    res.ent.valid = 1'b1;
    res.ent.page  = page;
    if (!cur.valid) begin
      res.ent.ctr = '0;
      res.hit     = 1'b0;
    end else begin
      if ((cur.page >> sh) == (page >> sh)) begin
        res.ent.ctr = (cur.ctr == CTR_MAX) ? cur.ctr : cur.ctr + CTR_W'(1);
      end else begin
        res.ent.ctr = (cur.ctr == '0) ? cur.ctr : cur.ctr - CTR_W'(1);
      end
      res.hit = (res.ent.ctr > CTR_THRESHOLD);
    end
    return res;
  endfunction

endpackage

// ----- design/pfp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfp_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pfp_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the prefetch predictor: clearing pass, per-request sequence, output valid.
// Depends on pfp_pkg.
module pfp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             m_tready_i,
  input  pfp_pkg::status_t status_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  output pfp_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_REM,
    S_READ,
    S_UPDATE
  } state_e;

  state_e state_q;
  logic   m_tvalid_q;
  logic   out_free;

  assign out_free = !m_tvalid_q || m_tready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == S_CLEAR);
    cmd_o.load   = (state_q == S_IDLE) && s_tvalid_i;
    cmd_o.mul    = (state_q == S_MUL);
    cmd_o.rem    = (state_q == S_REM);
    cmd_o.commit = (state_q == S_UPDATE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      m_tvalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (status_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid_i) begin
            state_q <= S_MUL;
          end
        end
        S_MUL:  state_q <= S_REM;
        S_REM:  state_q <= S_READ;
        S_READ: state_q <= S_UPDATE;
        S_UPDATE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
      if (cmd_o.commit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_tvalid_q;

endmodule

// ----- design/pfp_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the prefetch predictor: request registers, row reduction, tables, training.
// Depends on pfp_pkg and pfp_ram.
module pfp_dp #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned THREADS       = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfp_pkg::cmd_t                   cmd_i,
  input  logic [pfp_pkg::RID_W-1:0]       rid_i,
  input  logic [pfp_pkg::PC_W-1:0]        pc_i,
  input  logic [pfp_pkg::TID_W-1:0]       tid_i,
  input  logic [pfp_pkg::PAGE_W-1:0]      page_i,
  input  logic [pfp_pkg::SHIFT_W-1:0]     shift_i,
  output pfp_pkg::status_t                status_o,
  output logic                            prefetch_o
);

  localparam int unsigned RW     = $clog2(TABLE_ENTRIES);
  localparam int unsigned TW     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned TDEPTH = TABLE_ENTRIES * THREADS;
  localparam int unsigned TAW    = $clog2(TDEPTH);
  localparam logic [63:0] RECIP64 =
    ((64'd1 << (32 + RW)) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [33:0] RECIP  = RECIP64[33:0];

  logic [TW-1:0]                  tid_lut [1 << pfp_pkg::TID_W];
  logic [pfp_pkg::RID_W-1:0]      rid_q;
  logic [pfp_pkg::RID_W-1:0]      last_rid_q;
  logic [pfp_pkg::PC_W-1:0]       pc_q;
  logic [TW-1:0]                  tid_q;
  logic [pfp_pkg::PAGE_W-1:0]     page_q;
  logic [65:0]                    prod_q;
  logic [RW-1:0]                  row_q;
  logic                           out_bit_q;
  logic [TAW-1:0]                 clr_q;
  logic [31:0]                    quot;
  logic [43:0]                    qn;
  logic [31:0]                    rem_w;
  logic [TAW-1:0]                 slot;
  logic                           rep;
  logic                           clr_in_g;
  logic [pfp_pkg::ENTRY_W-1:0]    t_rd;
  logic [pfp_pkg::ENTRY_W-1:0]    g_rd;
  pfp_pkg::train_t                t_res;
  pfp_pkg::train_t                g_res;
  logic                           t_we;
  logic                           g_we;
  logic [TAW-1:0]                 t_waddr;
  logic [RW-1:0]                  g_waddr;
  logic [pfp_pkg::ENTRY_W-1:0]    t_wdata;
  logic [pfp_pkg::ENTRY_W-1:0]    g_wdata;

  for (genvar g = 0; g < (1 << pfp_pkg::TID_W); g++) begin : g_tid_lut
    assign tid_lut[g] = TW'(g % THREADS);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rid_q  <= rid_i;
      pc_q   <= pc_i;
      tid_q  <= tid_lut[tid_i];
      page_q <= page_i;
    end
    if (cmd_i.mul) begin
      prod_q <= 66'(pc_q) * 66'(RECIP);
    end
    if (cmd_i.rem) begin
      row_q <= rem_w[RW-1:0];
    end
    if (cmd_i.commit) begin
      out_bit_q <= !rep && (t_res.hit || g_res.hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rid_q <= pfp_pkg::RID_RESET;
      clr_q      <= '0;
    end else begin
      if (cmd_i.commit && !rep) begin
        last_rid_q <= rid_q;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + TAW'(1);
      end
    end
  end

  assign quot  = 32'(prod_q >> (32 + RW));
  assign qn    = 44'(quot) * 44'(TABLE_ENTRIES);
  assign rem_w = pc_q - qn[31:0];
  assign slot  = TAW'(TAW'(row_q) * TAW'(THREADS)) + TAW'(tid_q);
  assign rep   = (rid_q == last_rid_q);

  assign t_res = pfp_pkg::train_entry(pfp_pkg::entry_t'(t_rd), page_q, shift_i);
  assign g_res = pfp_pkg::train_entry(pfp_pkg::entry_t'(g_rd), page_q, shift_i);

  assign clr_in_g = ({1'b0, clr_q} < (TAW + 1)'(TABLE_ENTRIES));
  assign t_we     = cmd_i.clear || (cmd_i.commit && !rep);
  assign g_we     = (cmd_i.clear && clr_in_g) || (cmd_i.commit && !rep);
  assign t_waddr  = cmd_i.clear ? clr_q : slot;
  assign g_waddr  = cmd_i.clear ? clr_q[RW-1:0] : row_q;
  assign t_wdata  = cmd_i.clear ? '0 : t_res.ent;
  assign g_wdata  = cmd_i.clear ? '0 : g_res.ent;

  pfp_ram #(
    .WIDTH (pfp_pkg::ENTRY_W),
    .DEPTH (TDEPTH)
  ) u_thread_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (slot),
    .rdata_o (t_rd)
  );

  pfp_ram #(
    .WIDTH (pfp_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_global_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (row_q),
    .rdata_o (g_rd)
  );

  assign status_o.clr_last = (clr_q == TAW'(TDEPTH - 1));
  assign prefetch_o        = out_bit_q;

endmodule

// ----- design/pc_indexed_prefetch_predictor_unit.sv -----
`timescale 1ns / 1ps
// Top level of the PC-indexed prefetch predictor: stream ports, APB register, assertions.
// Depends on pfp_pkg, pfp_ctrl and pfp_dp.
//
// Usage: each request beat on the s_axis channel carries request id, program counter,
// thread id and page address; one response beat on m_axis carries the prefetch flag.
// The superpage_shift register sits at APB byte address 0; the user must write it only
// while idle, which the block itself does not enforce. Timing: one request is in flight
// at a time. The row reduction (reciprocal multiply, then remainder) is followed by the
// registered table read and the read-modify-write of both entries in the update step;
// the response is registered from that step, and the next request is taken back in idle.
// Reset: a clearing pass walks the per-thread table, one entry per cycle, over all
// TABLE_ENTRIES * THREADS entries (32768 at the defaults), clearing the global table in
// the same sweep; s_axis_tready stays low until it ends. APB writes are taken throughout.
// Stall: the response sits in an output register; the next request is still taken and
// its result holds in the update step until the waiting beat is taken.
module pc_indexed_prefetch_predictor_unit #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned THREADS       = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request_id[31:0], program_counter[63:32], thread_number[68:64], page_addr[116:69]
  input  logic [pfp_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // prefetch_enable[0]
  output logic [pfp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pfp_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [pfp_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [pfp_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic [pfp_pkg::SHIFT_W-1:0]   shift_q;
  logic [pfp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          prefetch;
  pfp_pkg::cmd_t                 cmd;
  pfp_pkg::status_t              status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= pfp_pkg::SHIFT_RESET;
    end else if (psel && penable && pwrite && pready
                 && (reg_idx == pfp_pkg::REG_SUPERPAGE_SHIFT)) begin
      shift_q <= pwdata[pfp_pkg::SHIFT_W-1:0];
    end
  end

  assign prdata = (reg_idx == pfp_pkg::REG_SUPERPAGE_SHIFT)
                ? pfp_pkg::APB_DATA_W'(shift_q) : '0;

  pfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  pfp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .THREADS       (THREADS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rid_i      (s_axis_tdata[31:0]),
    .pc_i       (s_axis_tdata[63:32]),
    .tid_i      (s_axis_tdata[68:64]),
    .page_i     (s_axis_tdata[116:69]),
    .shift_i    (shift_q),
    .status_o   (status),
    .prefetch_o (prefetch)
  );

  assign m_axis_tdata = pfp_pkg::M_TDATA_W'(prefetch);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result committed over a pending beat");

  a_commit_raises_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pc_indexed_prefetch_predictor_unit: stream request and
// response beats are checked against a local prefetch predictor. Depends on pfp_pkg.
module testbench;

  localparam int unsigned RID_W      = pfp_pkg::RID_W;
  localparam int unsigned PC_W       = pfp_pkg::PC_W;
  localparam int unsigned TID_W      = pfp_pkg::TID_W;
  localparam int unsigned PAGE_W     = pfp_pkg::PAGE_W;
  localparam int unsigned CTR_W      = pfp_pkg::CTR_W;
  localparam int unsigned S_TDATA_W  = pfp_pkg::S_TDATA_W;
  localparam int unsigned M_TDATA_W  = pfp_pkg::M_TDATA_W;
  localparam int unsigned APB_ADDR_W = pfp_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W = pfp_pkg::APB_DATA_W;
  localparam logic [RID_W-1:0] RID_RESET     = pfp_pkg::RID_RESET;
  localparam logic [2:0]       SHIFT_RESET   = pfp_pkg::SHIFT_RESET;
  localparam logic [CTR_W-1:0] CTR_MAX       = pfp_pkg::CTR_MAX;
  localparam logic [CTR_W-1:0] CTR_THRESHOLD = pfp_pkg::CTR_THRESHOLD;

  localparam int unsigned TABLE_ROWS   = 1024;
  localparam int unsigned THREAD_SLOTS = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_SUPERPAGE_SHIFT =
    APB_ADDR_W'(4 * pfp_pkg::REG_SUPERPAGE_SHIFT);

  typedef struct {
    bit [RID_W-1:0]  rid;
    bit [PC_W-1:0]   pc;
    bit [TID_W-1:0]  tid;
    bit [PAGE_W-1:0] page;
    int              gap;
  } page_req_t;

  typedef struct packed {
    bit              seen;
    bit [PAGE_W-1:0] page;
    bit [CTR_W-1:0]  ctr;
  } stream_slot_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  // request_id[31:0], program_counter[63:32], thread_number[68:64], page_addr[116:69]
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // prefetch_enable[0]
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pc_indexed_prefetch_predictor_unit #(
    .TABLE_ENTRIES(TABLE_ROWS),
    .THREADS      (THREAD_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  stream_slot_t    thread_tab [TABLE_ROWS*THREAD_SLOTS];
  stream_slot_t    global_tab [TABLE_ROWS];
  bit [RID_W-1:0]  last_rid = RID_RESET;
  int unsigned     page_shift = SHIFT_RESET;

  page_req_t       req_q[$];
  page_req_t       cur_req;
  bit              have_req = 1'b0;
  bit              expected_prefetch_q[$];
  bit              s_taken = 1'b0;
  bit              m_taken = 1'b0;
  bit              tx_quiet = 1'b0;
  bit              rx_quiet = 1'b0;
  int              rx_stall = 0;
  int              n_errors = 0;
  bit [RID_W-1:0]  last_pushed_rid = RID_RESET;
  bit [PC_W-1:0]   pc_pool [8];
  bit [TID_W-1:0]  tid_pool [4];
  bit [PAGE_W-1:0] page_pool [8];

  function automatic stream_slot_t train_slot(stream_slot_t cur, bit [PAGE_W-1:0] page);
    stream_slot_t nxt;
    nxt.seen = 1'b1;
    nxt.page = page;
    if (!cur.seen) begin
      nxt.ctr = '0;
    end else if ((cur.page >> page_shift) == (page >> page_shift)) begin
      nxt.ctr = (cur.ctr == CTR_MAX) ? cur.ctr : cur.ctr + 1'b1;
    end else begin
      nxt.ctr = (cur.ctr == '0) ? cur.ctr : cur.ctr - 1'b1;
    end
    return nxt;
  endfunction

  function automatic bit predict_prefetch(logic [S_TDATA_W-1:0] beat);
    bit [RID_W-1:0]  rid;
    bit [PC_W-1:0]   pc;
    bit [TID_W-1:0]  tid;
    bit [PAGE_W-1:0] page;
    int unsigned     row;
    int unsigned     slot;
    bit              hit_thread;
    bit              hit_global;
    stream_slot_t    nt;
    stream_slot_t    ng;
    rid  = beat[31:0];
    pc   = beat[63:32];
    tid  = beat[68:64];
    page = beat[116:69];
    if (rid == last_rid) return 1'b0;
    row  = pc % TABLE_ROWS;
    slot = row * THREAD_SLOTS + (tid % THREAD_SLOTS);
    nt = train_slot(thread_tab[slot], page);
    ng = train_slot(global_tab[row], page);
    hit_thread = thread_tab[slot].seen && (nt.ctr > CTR_THRESHOLD);
    hit_global = global_tab[row].seen && (ng.ctr > CTR_THRESHOLD);
    thread_tab[slot] = nt;
    global_tab[row]  = ng;
    last_rid = rid;
    return hit_thread || hit_global;
  endfunction

  function automatic bit [PAGE_W-1:0] rand48();
    bit [63:0] w;
    w = {$urandom, $urandom};
    return w[PAGE_W-1:0];
  endfunction

  function automatic bit [RID_W-1:0] next_rid();
    if ($urandom_range(0, 24) == 0) return last_pushed_rid;
    return $urandom;
  endfunction

  function automatic void push_req(bit [RID_W-1:0] rid, bit [PC_W-1:0] pc,
                                   bit [TID_W-1:0] tid, bit [PAGE_W-1:0] page);
    page_req_t r;
    r.rid  = rid;
    r.pc   = pc;
    r.tid  = tid;
    r.page = page;
    r.gap  = tx_quiet ? 0 : $urandom_range(0, 14);
    req_q.insert(req_q.size(), r);
    last_pushed_rid = rid;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: idle for each request's gap, then present its beat and hold it until taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_taken)) begin
      if (!have_req && req_q.size() > 0) begin
        cur_req  = req_q.pop_front();
        have_req = 1'b1;
      end
      if (have_req && cur_req.gap == 0) begin
        s_axis_tdata  <= {3'b000, cur_req.page, cur_req.tid, cur_req.pc, cur_req.rid};
        s_axis_tvalid <= 1'b1;
        have_req = 1'b0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (have_req) cur_req.gap--;
      end
    end
  end

  always @(negedge clk_i) begin
    if (m_taken) rx_stall = rx_quiet ? 0 : $urandom_range(0, 14);
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    s_taken <= s_axis_tvalid && s_axis_tready;
    m_taken <= m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_prefetch_q.insert(expected_prefetch_q.size(),
                                 predict_prefetch(s_axis_tdata));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_prefetch_q.size() == 0) begin
        $error("prefetch_enable: no beat expected, actual %0d", m_axis_tdata[0]);
        n_errors++;
      end else if (m_axis_tdata[0] !== expected_prefetch_q[0]) begin
        $error("prefetch_enable: expected %0d, actual %0d", expected_prefetch_q[0],
               m_axis_tdata[0]);
        n_errors++;
        void'(expected_prefetch_q.pop_front());
      end else begin
        void'(expected_prefetch_q.pop_front());
      end
    end
  end

  task automatic apb_access(bit wr, bit [APB_ADDR_W-1:0] addr, bit [APB_DATA_W-1:0] wdata,
                            output bit [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_superpage_shift();
    bit [APB_DATA_W-1:0] rd;
    apb_access(1'b0, ADDR_SUPERPAGE_SHIFT, '0, rd);
    if (rd !== APB_DATA_W'(page_shift)) begin
      $error("superpage_shift: expected %0d, actual %0d", page_shift, rd);
      n_errors++;
    end
  endtask

  task automatic set_superpage_shift(int unsigned value);
    bit [APB_DATA_W-1:0] rd;
    apb_access(1'b1, ADDR_SUPERPAGE_SHIFT, APB_DATA_W'(value), rd);
    page_shift = value;
    check_superpage_shift();
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || have_req || s_axis_tvalid || expected_prefetch_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic refill_pools();
    for (int i = 0; i < 8; i++) begin
      pc_pool[i]   = (i == 0) ? '0 : (i == 1) ? PC_W'(TABLE_ROWS - 1) : $urandom_range(0, 1023);
      page_pool[i] = rand48();
    end
    for (int i = 0; i < 4; i++) tid_pool[i] = $urandom_range(0, 31);
  endtask

  // Mostly trained streams per pc row and thread, with jumps and unrelated requests mixed in.
  task automatic push_random(int n);
    int              left;
    int              run_len;
    int              p;
    int              t;
    bit [PAGE_W-1:0] span_mask;
    bit [PAGE_W-1:0] pg;
    bit [TID_W-1:0]  tid;
    left = n;
    span_mask = (48'd1 << page_shift) - 1;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        push_req(next_rid(), $urandom, TID_W'($urandom), rand48());
        left--;
      end else begin
        p = $urandom_range(0, 7);
        t = $urandom_range(0, 3);
        run_len = $urandom_range(3, 10);
        for (int i = 0; i < run_len && left > 0; i++) begin
          if ($urandom_range(0, 9) == 0) page_pool[p] = rand48();
          else if ($urandom_range(0, 7) == 0) page_pool[p] += (48'd1 << page_shift);
          pg  = page_pool[p] ^ (rand48() & span_mask);
          tid = ($urandom_range(0, 3) == 0) ? TID_W'($urandom) : tid_pool[t];
          push_req(next_rid(), ($urandom & ~32'h3FF) | pc_pool[p], tid, pg);
          left--;
        end
      end
    end
  endtask

  initial begin
    int unsigned shifts [5];
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    check_superpage_shift();

    push_req(RID_RESET, '0, '0, '0);
    push_req('0, '0, '0, '0);
    for (int i = 0; i < 5; i++) push_req(100 + i, '0, '0, 48'd3);
    push_req(104, '0, '0, 48'd3);
    push_req(200, '0, '0, '1);
    push_req('1, '1, '1, '1);
    for (int i = 0; i < 5; i++) push_req(300 + i, 32'h3FF, TID_W'(5 + i), '1);
    push_req(400, 32'h1234_0000, '0, 48'd1);
    push_req(401, 32'h0000_0400, '1, 48'h8000_0000_0000);
    wait_idle();

    shifts = '{0, 6, 7, $urandom_range(1, 5), SHIFT_RESET};
    foreach (shifts[ph]) begin
      set_superpage_shift(shifts[ph]);
      refill_pools();
      for (int k = 0; k < 3; k++) begin
        tx_quiet = (k == 1);
        rx_quiet = (k == 2);
        push_random(40);
        wait_idle();
      end
    end

    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
